/* design/zwpa_pkg.sv */
// Package of the zoned write pointer allocator: widths, codes and transaction types.
`default_nettype none

package zwpa_pkg;

  localparam int unsigned LEN_W      = 40;
  localparam int unsigned ZB_W       = 24;
  localparam int unsigned ZN_W       = 11;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned STAT_W     = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned DIVD_W     = LEN_W + 1;
  localparam int unsigned DIV_CNT_W  = $clog2(DIVD_W + 1);

  localparam int unsigned NUM_ZONES_DEF = 1024;
  localparam int unsigned ADDR_BITS_DEF = 40;

  localparam logic [ZB_W-1:0] ZB_RST = 24'd65536;
  localparam logic [ZN_W-1:0] NZ_RST = 11'd1024;

  localparam logic [OP_W-1:0] OP_ALLOC     = 2'd0;
  localparam logic [OP_W-1:0] OP_MARK_FREE = 2'd1;
  localparam logic [OP_W-1:0] OP_MARK_USED = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NO_SPACE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_MISMATCH = 2'd2;
  localparam logic [STAT_W-1:0] STAT_RANGE    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_ZONE_BLOCKS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ZONES_IN_USE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SEQ    = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]  opcode;
    logic [LEN_W-1:0] block_offset;
    logic [LEN_W-1:0] block_length;
  } zwpa_req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [LEN_W-1:0]  alloc_offset;
    logic [LEN_W-1:0]  alloc_length;
    logic [LEN_W-1:0]  free_blocks;
  } zwpa_rsp_t;

  typedef struct packed {
    logic [DIVD_W-1:0] quot_a;
    logic [ZB_W-1:0]   rem_a;
    logic [DIVD_W-1:0] quot_b;
    logic [ZB_W-1:0]   rem_b;
  } zwpa_div_res_t;

endpackage

`default_nettype wire

/* design/zoned_write_pointer_allocator.sv */
// Top level of the zoned write pointer allocator with its zone pointer memory.
//
//   Channel  Signals                                   Direction
//   in       in_valid_i / in_ready_o / in_data_i       request transaction in
//   out      out_valid_o / out_ready_i / out_data_o    result transaction out
//   cfg      cfg_valid_i / cfg_ready_o / cfg_index_i / cfg_data_i   register write in
//
// Allocate scans the zones in order from the scan start; the pointer memory delivers
// one zone per cycle. Mark free and mark used run the zone division, check the range
// and then write the pointers of the covered zones. After reset a clearing pass zeroes
// the pointer memory; requests wait, register writes are taken. One request is in work
// at a time and register writes are taken only between requests; a finished result
// waits in the output register while the next request is taken.
`default_nettype none

module zoned_write_pointer_allocator import zwpa_pkg::*; #(
  parameter int unsigned NUM_ZONES = NUM_ZONES_DEF,
  parameter int unsigned ADDR_BITS = ADDR_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire zwpa_req_t             in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output zwpa_rsp_t                  out_data_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned ZW    = $clog2(NUM_ZONES);
  localparam int unsigned SUM_W = ((ADDR_BITS > LEN_W) ? ADDR_BITS : LEN_W) + 1;
  localparam int unsigned PRD_W = ZN_W + ZB_W;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SCAN, S_AMUL, S_AWR, S_DIV, S_RCHK, S_UCHK, S_FILL, S_RESP
  } state_e;

  state_e              state_q;
  zwpa_req_t           req_q;
  zwpa_rsp_t           out_q;
  logic                out_vld_q;
  logic [ZB_W-1:0]     zb_q;
  logic [ZN_W-1:0]     zones_q, scan_start_q;
  logic [ADDR_BITS-1:0] free_q;
  logic [ZW-1:0]       clr_q;
  logic [ZN_W-1:0]     issue_z_q, chk_z_q, cur_z_q, zone_q, end_z_q, fill_z_q;
  logic                chk_vld_q;
  logic [ZB_W-1:0]     wp_q, zoff_q, fill_val_q;
  logic [PRD_W-1:0]    prod_q;
  logic [STAT_W-1:0]   res_stat_q;
  logic [LEN_W-1:0]    res_off_q, res_len_q;

  logic [ZB_W-1:0]     mem_q [NUM_ZONES];
  logic [ZB_W-1:0]     mem_rdata_q;
  logic                mem_we, mem_re;
  logic [ZW-1:0]       mem_waddr, mem_raddr;
  logic [ZB_W-1:0]     mem_wdata;

  logic                in_acc, div_start, div_done;
  zwpa_div_res_t       div_res;
  logic [ZN_W-1:0]     nz;
  logic                issue_ok, fits, range_ok, mark_op;
  logic [ZB_W-1:0]     head;
  logic [ZB_W:0]       nwp;
  logic [SUM_W-1:0]    sum_free;
  logic                underflow;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = (state_q == S_IDLE) || (state_q == S_CLEAR);

  assign mark_op   = (in_data_i.opcode == OP_MARK_FREE) || (in_data_i.opcode == OP_MARK_USED);
  assign div_start = in_acc && mark_op && (zb_q != '0);

  zwpa_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .dvd_a_i (DIVD_W'(in_data_i.block_offset)),
    .dvd_b_i (DIVD_W'(in_data_i.block_offset) + DIVD_W'(in_data_i.block_length)),
    .dvs_i   (zb_q),
    .done_o  (div_done),
    .res_o   (div_res)
  );

  always_comb begin
    nz        = ({21'd0, zones_q} > 32'(NUM_ZONES)) ? ZN_W'(NUM_ZONES) : zones_q;
    issue_ok  = issue_z_q < nz;
    fits      = (DIVD_W'(mem_rdata_q) + DIVD_W'(req_q.block_length)) <= DIVD_W'(zb_q);
    head      = zb_q - div_res.rem_a;
    range_ok  = (div_res.quot_a < DIVD_W'(nz)) &&
                (LEN_W'(head) <= req_q.block_length) &&
                (div_res.rem_b == '0) &&
                (div_res.quot_b <= DIVD_W'(nz));
    nwp       = (ZB_W + 1)'(wp_q) + (ZB_W + 1)'(req_q.block_length);
    sum_free  = SUM_W'(free_q) + SUM_W'(req_q.block_length);
    underflow = SUM_W'(req_q.block_length) > SUM_W'(free_q);
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = ZW'(issue_z_q);
    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
      end
      S_SCAN: begin
        mem_re = issue_ok;
      end
      S_AWR: begin
        mem_we    = 1'b1;
        mem_waddr = ZW'(cur_z_q);
        mem_wdata = nwp[ZB_W-1:0];
      end
      S_RCHK: begin
        if (range_ok && (req_q.opcode == OP_MARK_FREE)) begin
          mem_we    = 1'b1;
          mem_waddr = ZW'(div_res.quot_a[ZN_W-1:0]);
          mem_wdata = div_res.rem_a;
        end
        if (range_ok && (req_q.opcode == OP_MARK_USED)) begin
          mem_re    = 1'b1;
          mem_raddr = ZW'(div_res.quot_a[ZN_W-1:0]);
        end
      end
      S_UCHK: begin
        if ((mem_rdata_q == zoff_q) && !underflow) begin
          mem_we    = 1'b1;
          mem_waddr = ZW'(zone_q);
          mem_wdata = zb_q;
        end
      end
      S_FILL: begin
        if (fill_z_q < end_z_q) begin
          mem_we    = 1'b1;
          mem_waddr = ZW'(fill_z_q);
          mem_wdata = fill_val_q;
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      req_q        <= '0;
      out_q        <= '0;
      out_vld_q    <= 1'b0;
      zb_q         <= ZB_RST;
      zones_q      <= NZ_RST;
      scan_start_q <= '0;
      free_q       <= '0;
      clr_q        <= '0;
      issue_z_q    <= '0;
      chk_z_q      <= '0;
      chk_vld_q    <= 1'b0;
      cur_z_q      <= '0;
      zone_q       <= '0;
      end_z_q      <= '0;
      fill_z_q     <= '0;
      wp_q         <= '0;
      zoff_q       <= '0;
      fill_val_q   <= '0;
      prod_q       <= '0;
      res_stat_q   <= STAT_OK;
      res_off_q    <= '0;
      res_len_q    <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_ZONE_BLOCKS:  zb_q <= cfg_data_i[ZB_W-1:0];
          CFG_ZONES_IN_USE: zones_q <= cfg_data_i[ZN_W-1:0];
          CFG_FIRST_SEQ:    scan_start_q <= cfg_data_i[ZN_W-1:0];
          default:          zones_q <= zones_q;
        endcase
      end

      if (out_vld_q && out_ready_i && (state_q != S_RESP)) begin
        out_vld_q <= 1'b0;
      end

      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == ZW'(NUM_ZONES - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            req_q      <= in_data_i;
            res_off_q  <= '0;
            res_len_q  <= '0;
            chk_vld_q  <= 1'b0;
            issue_z_q  <= scan_start_q;
            if (in_data_i.opcode == OP_ALLOC) begin
              res_stat_q <= STAT_OK;
              state_q    <= S_SCAN;
            end else if (div_start) begin
              res_stat_q <= STAT_OK;
              state_q    <= S_DIV;
            end else begin
              res_stat_q <= STAT_RANGE;
              state_q    <= S_RESP;
            end
          end
        end
        S_SCAN: begin
          if (chk_vld_q && fits) begin
            cur_z_q   <= chk_z_q;
            wp_q      <= mem_rdata_q;
            chk_vld_q <= 1'b0;
            state_q   <= S_AMUL;
          end else begin
            chk_vld_q <= issue_ok;
            chk_z_q   <= issue_z_q;
            if (issue_ok) begin
              issue_z_q <= issue_z_q + 1'b1;
            end
            if (!chk_vld_q && !issue_ok) begin
              res_stat_q <= STAT_NO_SPACE;
              state_q    <= S_RESP;
            end
          end
        end
        S_AMUL: begin
          prod_q  <= PRD_W'(cur_z_q) * PRD_W'(zb_q);
          state_q <= S_AWR;
        end
        S_AWR: begin
          res_off_q <= LEN_W'((PRD_W + 1)'(prod_q) + (PRD_W + 1)'(wp_q));
          res_len_q <= req_q.block_length;
          if (nwp == (ZB_W + 1)'(zb_q)) begin
            scan_start_q <= cur_z_q + 1'b1;
          end
          state_q <= S_RESP;
        end
        S_DIV: begin
          if (div_done) begin
            state_q <= S_RCHK;
          end
        end
        S_RCHK: begin
          zone_q   <= div_res.quot_a[ZN_W-1:0];
          zoff_q   <= div_res.rem_a;
          end_z_q  <= div_res.quot_b[ZN_W-1:0];
          fill_z_q <= div_res.quot_a[ZN_W-1:0] + 1'b1;
          if (!range_ok) begin
            res_stat_q <= STAT_RANGE;
            state_q    <= S_RESP;
          end else if (req_q.opcode == OP_MARK_FREE) begin
            free_q     <= (sum_free > SUM_W'({ADDR_BITS{1'b1}})) ? {ADDR_BITS{1'b1}}
                                                               : sum_free[ADDR_BITS-1:0];
            fill_val_q <= '0;
            state_q    <= S_FILL;
          end else begin
            state_q <= S_UCHK;
          end
        end
        S_UCHK: begin
          if (mem_rdata_q != zoff_q) begin
            res_stat_q <= STAT_MISMATCH;
            state_q    <= S_RESP;
          end else if (underflow) begin
            res_stat_q <= STAT_NO_SPACE;
            state_q    <= S_RESP;
          end else begin
            free_q     <= ADDR_BITS'(SUM_W'(free_q) - SUM_W'(req_q.block_length));
            fill_val_q <= zb_q;
            state_q    <= S_FILL;
          end
        end
        S_FILL: begin
          if (fill_z_q < end_z_q) begin
            fill_z_q <= fill_z_q + 1'b1;
          end else begin
            state_q <= S_RESP;
          end
        end
        S_RESP: begin
          if (!out_vld_q || out_ready_i) begin
            out_q     <= '{status:       res_stat_q,
                           alloc_offset: res_off_q,
                           alloc_length: res_len_q,
                           free_blocks:  LEN_W'(free_q)};
            out_vld_q <= 1'b1;
            state_q   <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* design/zwpa_divider.sv */
// Radix-2 restoring divider that divides two dividends by one shared divisor.
`default_nettype none

module zwpa_divider import zwpa_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [DIVD_W-1:0] dvd_a_i,
  input  wire logic [DIVD_W-1:0] dvd_b_i,
  input  wire logic [ZB_W-1:0]   dvs_i,
  output logic                   done_o,
  output zwpa_div_res_t          res_o
);

  logic                 busy_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIVD_W-1:0]    quo_a_q, quo_b_q;
  logic [ZB_W-1:0]      rem_a_q, rem_b_q, dvs_q;
  logic [ZB_W:0]        trial_a, trial_b, diff_a, diff_b;
  logic                 ge_a, ge_b;

  always_comb begin
    trial_a = {rem_a_q, quo_a_q[DIVD_W-1]};
    trial_b = {rem_b_q, quo_b_q[DIVD_W-1]};
    diff_a  = trial_a - {1'b0, dvs_q};
    diff_b  = trial_b - {1'b0, dvs_q};
    ge_a    = trial_a >= {1'b0, dvs_q};
    ge_b    = trial_b >= {1'b0, dvs_q};
  end

  assign done_o = busy_q && (cnt_q == '0);
  assign res_o  = '{quot_a: quo_a_q, rem_a: rem_a_q, quot_b: quo_b_q, rem_b: rem_b_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      cnt_q   <= '0;
      quo_a_q <= '0;
      quo_b_q <= '0;
      rem_a_q <= '0;
      rem_b_q <= '0;
      dvs_q   <= '0;
    end else if (start_i) begin
      busy_q  <= 1'b1;
      cnt_q   <= DIV_CNT_W'(DIVD_W);
      quo_a_q <= dvd_a_i;
      quo_b_q <= dvd_b_i;
      rem_a_q <= '0;
      rem_b_q <= '0;
      dvs_q   <= dvs_i;
    end else if (busy_q) begin
      if (cnt_q != '0) begin
        cnt_q   <= cnt_q - 1'b1;
        quo_a_q <= {quo_a_q[DIVD_W-2:0], ge_a};
        quo_b_q <= {quo_b_q[DIVD_W-2:0], ge_b};
        rem_a_q <= ge_a ? diff_a[ZB_W-1:0] : trial_a[ZB_W-1:0];
        rem_b_q <= ge_b ? diff_b[ZB_W-1:0] : trial_b[ZB_W-1:0];
      end else begin
        busy_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench of the zoned write pointer allocator, with its scoreboard class.
import zwpa_pkg::*;

class zone_scoreboard;
  logic [ZB_W-1:0]  zone_size;
  logic [ZN_W-1:0]  zone_count;
  logic [ZN_W-1:0]  scan_zone;
  logic [ZB_W-1:0]  write_ptr [NUM_ZONES_DEF];
  logic [LEN_W-1:0] free_total;
  zwpa_rsp_t        awaited_q [$];
  int unsigned      errors;
  int unsigned      status_seen [4];
  bit               hit_ceiling;

  function new();
    zone_size   = ZB_RST;
    zone_count  = NZ_RST;
    scan_zone   = '0;
    free_total  = '0;
    errors      = 0;
    hit_ceiling = 1'b0;
    foreach (write_ptr[i]) write_ptr[i] = '0;
    foreach (status_seen[i]) status_seen[i] = 0;
  endfunction

  function longint unsigned active_zones();
    return (zone_count > NUM_ZONES_DEF) ? NUM_ZONES_DEF : zone_count;
  endfunction

  function void load_register(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] value);
    case (idx)
      CFG_ZONE_BLOCKS:  zone_size  = value[ZB_W-1:0];
      CFG_ZONES_IN_USE: zone_count = value[ZN_W-1:0];
      CFG_FIRST_SEQ:    scan_zone  = value[ZN_W-1:0];
      default: ;
    endcase
  endfunction

  function bit range_fits(input longint unsigned off, input longint unsigned len,
                          output longint unsigned zone, output longint unsigned zoff,
                          output longint unsigned extra);
    longint unsigned zb, nz, head, rest;
    zb    = zone_size;
    nz    = active_zones();
    zone  = 0;
    zoff  = 0;
    extra = 0;
    if (zb == 0) return 1'b0;
    zone = off / zb;
    zoff = off % zb;
    if (zone >= nz) return 1'b0;
    head = zb - zoff;
    if (len < head) return 1'b0;
    rest = len - head;
    if (rest % zb != 0) return 1'b0;
    extra = rest / zb;
    return extra <= nz - 1 - zone;
  endfunction

  function void load_pointers(input longint unsigned zone, input longint unsigned extra,
                              input logic [ZB_W-1:0] first, input logic [ZB_W-1:0] others);
    write_ptr[zone] = first;
    for (longint unsigned k = 1; k <= extra; k++) write_ptr[zone + k] = others;
  endfunction

  function zwpa_rsp_t apply_zone_op(input zwpa_req_t req);
    zwpa_rsp_t       rsp;
    longint unsigned off, len, nz, z, zone, zoff, extra, sum;
    rsp = '0;
    off = req.block_offset;
    len = req.block_length;
    case (req.opcode)
      OP_ALLOC: begin
        nz = active_zones();
        z  = scan_zone;
        while (z < nz && longint'(write_ptr[z]) + len > zone_size) z++;
        if (z >= nz) begin
          rsp.status = STAT_NO_SPACE;
        end else begin
          rsp.status       = STAT_OK;
          rsp.alloc_offset = LEN_W'(z * zone_size + write_ptr[z]);
          rsp.alloc_length = LEN_W'(len);
          sum              = longint'(write_ptr[z]) + len;
          write_ptr[z]     = ZB_W'(sum);
          if (sum == zone_size) scan_zone = ZN_W'(z + 1);
        end
      end
      OP_MARK_FREE: begin
        if (!range_fits(off, len, zone, zoff, extra)) begin
          rsp.status = STAT_RANGE;
        end else begin
          rsp.status = STAT_OK;
          sum        = longint'(free_total) + len;
          free_total = (sum > {LEN_W{1'b1}}) ? {LEN_W{1'b1}} : LEN_W'(sum);
          if (free_total == {LEN_W{1'b1}}) hit_ceiling = 1'b1;
          load_pointers(zone, extra, ZB_W'(zoff), '0);
        end
      end
      OP_MARK_USED: begin
        if (!range_fits(off, len, zone, zoff, extra)) begin
          rsp.status = STAT_RANGE;
        end else if (longint'(write_ptr[zone]) != zoff) begin
          rsp.status = STAT_MISMATCH;
        end else if (len > free_total) begin
          rsp.status = STAT_NO_SPACE;
        end else begin
          rsp.status = STAT_OK;
          free_total = free_total - LEN_W'(len);
          load_pointers(zone, extra, zone_size, zone_size);
        end
      end
      default: begin
        rsp.status = STAT_RANGE;
      end
    endcase
    rsp.free_blocks = free_total;
    return rsp;
  endfunction

  function void note_request(input zwpa_req_t req);
    awaited_q.push_back(apply_zone_op(req));
  endfunction

  function void compare_field(input string name, input logic [LEN_W-1:0] want,
                              input logic [LEN_W-1:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= 40)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  function void check_result(input zwpa_rsp_t got);
    zwpa_rsp_t want;
    if (awaited_q.size() == 0) begin
      errors++;
      if (errors <= 40)
        $display("%0t: result with no request outstanding, expected none, actual %0h",
                 $time, got);
      return;
    end
    want = awaited_q.pop_front();
    status_seen[want.status]++;
    compare_field("status", want.status, got.status);
    compare_field("alloc_offset", want.alloc_offset, got.alloc_offset);
    compare_field("alloc_length", want.alloc_length, got.alloc_length);
    compare_field("free_blocks", want.free_blocks, got.free_blocks);
  endfunction
endclass

module tb_top;
  import zwpa_pkg::*;

  localparam longint unsigned DZ = 65536;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_valid   = 1'b0;
  zwpa_req_t             in_data    = '0;
  logic                  out_ready  = 1'b0;
  logic                  cfg_valid  = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = CFG_ZONE_BLOCKS;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;
  logic                  in_ready;
  logic                  out_valid;
  logic                  cfg_ready;
  zwpa_rsp_t             out_data;

  int unsigned send_gap_pct   = 8;
  int unsigned recv_stall_pct = 76;
  int unsigned requests_sent  = 0;
  int unsigned settings_run   = 0;

  zone_scoreboard sb = new();

  always #1 clk = ~clk;

  zoned_write_pointer_allocator i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  function automatic logic [LEN_W-1:0] rand40();
    logic [63:0] v;
    v = {$urandom(), $urandom()};
    return v[LEN_W-1:0];
  endfunction

  function automatic zwpa_req_t make_req(input logic [OP_W-1:0] op,
                                         input longint unsigned off,
                                         input longint unsigned len);
    zwpa_req_t r;
    r.opcode       = op;
    r.block_offset = LEN_W'(off);
    r.block_length = LEN_W'(len);
    return r;
  endfunction

  function automatic zwpa_req_t random_request();
    longint unsigned zb, nz, zone, zoff, extra, len, room;
    logic [OP_W-1:0] op;
    int unsigned     pick;
    zb   = sb.zone_size;
    nz   = sb.active_zones();
    pick = $urandom_range(99);
    if (pick < 12)
      return make_req(OP_W'($urandom_range(3)), rand40(),
                      $urandom_range(1) ? rand40() : $urandom_range(zb * 2));
    if (pick < 52) begin
      pick = $urandom_range(19);
      if (pick < 2) len = 0;
      else if (pick < 4) len = rand40();
      else if (pick < 8 && sb.scan_zone < nz && sb.write_ptr[sb.scan_zone] <= zb)
        len = zb - sb.write_ptr[sb.scan_zone];
      else if (pick < 11) len = $urandom_range(zb);
      else len = $urandom_range(zb / 16 + 1);
      return make_req(OP_ALLOC, rand40(), len);
    end
    op    = (pick < 78) ? OP_MARK_FREE : OP_MARK_USED;
    zone  = $urandom_range(nz - 1);
    room  = nz - 1 - zone;
    extra = ($urandom_range(19) == 0) ? $urandom_range(room)
                                      : $urandom_range(room < 3 ? room : 3);
    if (op == OP_MARK_USED && sb.write_ptr[zone] < zb && $urandom_range(7) != 0)
      zoff = sb.write_ptr[zone];
    else if ($urandom_range(2) == 0) zoff = 0;
    else zoff = $urandom_range(zb - 1);
    len = zb - zoff + extra * zb;
    case ($urandom_range(11))
      0: len = len + 1;
      1: len = len - 1;
      2: zone = nz + $urandom_range(7);
      default: ;
    endcase
    return make_req(op, zone * zb + zoff, len);
  endfunction

  task automatic send_request(input zwpa_req_t req);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    sb.note_request(req);
    requests_sent++;
    @(negedge clk);
  endtask

  task automatic wait_for_idle();
    in_valid <= 1'b0;
    while (sb.awaited_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic load_setting(input logic [ZB_W-1:0] zb, input logic [ZN_W-1:0] nz,
                              input logic [ZN_W-1:0] first_zone);
    logic [CFG_IDX_W-1:0]  reg_idx [3];
    logic [CFG_DATA_W-1:0] value   [3];
    reg_idx = '{CFG_ZONE_BLOCKS, CFG_ZONES_IN_USE, CFG_FIRST_SEQ};
    value   = '{CFG_DATA_W'(zb), CFG_DATA_W'(nz), CFG_DATA_W'(first_zone)};
    wait_for_idle();
    cfg_valid <= 1'b1;
    for (int i = 0; i < 3; i++) begin
      cfg_index <= reg_idx[i];
      cfg_data  <= value[i];
      do @(posedge clk); while (!cfg_ready);
      sb.load_register(reg_idx[i], value[i]);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
    settings_run++;
  endtask

  task automatic run_phase(input logic [ZB_W-1:0] zb, input logic [ZN_W-1:0] nz,
                           input logic [ZN_W-1:0] first_zone, input int unsigned count,
                           input int unsigned whole_frees);
    load_setting(zb, nz, first_zone);
    repeat (whole_frees) send_request(make_req(OP_MARK_FREE, 0, longint'(nz) * zb));
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(59) == 0) wait_for_idle();
      send_request(random_request());
    end
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_request(make_req(OP_ALLOC, 0, 0));
    send_request(make_req(OP_ALLOC, 0, DZ));
    send_request(make_req(OP_ALLOC, 0, 100));
    send_request(make_req(OP_ALLOC, 0, DZ + 1));
    send_request(make_req(OP_ALLOC, {LEN_W{1'b1}}, {LEN_W{1'b1}}));
    send_request(make_req(2'b11, {LEN_W{1'b1}}, {LEN_W{1'b1}}));
    send_request(make_req(OP_MARK_FREE, {LEN_W{1'b1}}, DZ));
    send_request(make_req(OP_MARK_FREE, 2 * DZ + 5, DZ - 5));
    send_request(make_req(OP_MARK_FREE, 3 * DZ, DZ - 1));
    send_request(make_req(OP_MARK_FREE, 3 * DZ, DZ + 1));
    send_request(make_req(OP_MARK_FREE, 1023 * DZ, DZ));
    send_request(make_req(OP_MARK_FREE, 1023 * DZ, 2 * DZ));
    send_request(make_req(OP_MARK_USED, 2 * DZ, DZ));
    send_request(make_req(OP_MARK_USED, 2 * DZ + 5, DZ - 5));
    send_request(make_req(OP_MARK_USED, 4 * DZ, 10 * DZ));
    send_request(make_req(OP_MARK_USED, {LEN_W{1'b1}}, {LEN_W{1'b1}}));
    send_request(make_req(OP_MARK_FREE, 0, 1024 * DZ));
    send_request(make_req(OP_ALLOC, 0, DZ));
    send_request(make_req(OP_MARK_USED, 0, DZ));
    send_request(make_req(OP_ALLOC, 0, 0));
    send_request(make_req(OP_ALLOC, 0, 1));
    send_request(make_req(OP_MARK_FREE, 5 * DZ + DZ - 1, 1));

    run_phase(24'd65536, 11'd1024, 11'd0, 250, 0);
    run_phase(24'd1, 11'd1, 11'd0, 120, 0);

    send_gap_pct   = 76;
    recv_stall_pct = 8;
    run_phase(24'd16777215, 11'd1024, 11'd1024, 120, 0);
    run_phase(24'd4096, 11'd64, 11'd3, 250, 0);

    send_gap_pct   = 0;
    recv_stall_pct = 0;
    run_phase(24'd7, 11'd5, 11'd2, 160, 0);
    run_phase(24'd16777215, 11'd1024, 11'd0, 120, 70);
    run_phase(24'd300, 11'd1023, 11'd1000, 180, 0);

    wait_for_idle();
    repeat (64) @(negedge clk);

    $display("Ran %0d requests across %0d register settings; free count ceiling reached: %0d.",
             requests_sent, settings_run, sb.hit_ceiling);
    $display("Statuses seen: ok %0d, no space %0d, pointer mismatch %0d, range error %0d.",
             sb.status_seen[STAT_OK], sb.status_seen[STAT_NO_SPACE],
             sb.status_seen[STAT_MISMATCH], sb.status_seen[STAT_RANGE]);
    if (sb.errors == 0 && sb.awaited_q.size() == 0) begin
      $display("zoned_write_pointer_allocator verification clean");
    end else begin
      $display("zoned_write_pointer_allocator verification failed");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("zoned_write_pointer_allocator verification failed");
    $finish;
  end
endmodule

/* zoned_write_pointer_allocator.f */
design/zwpa_pkg.sv
design/zwpa_divider.sv
design/zoned_write_pointer_allocator.sv
tb/tb_top.sv
